// ----- src/tlni_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlni_pkg: shared types and constants of the torus lattice neighbor indexer
// Field widths, register indexes, slot order of the neighbor sequence and
// the per-step divide function used by the front pipeline.
// ----------------------------------------------------------------------------
package tlni_pkg;

  localparam int unsigned IDX_W      = 12;        // agent / neighbor index width
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned RW_W       = 13;        // row_width register width
  localparam int unsigned POP_W      = 2 * RW_W;  // width of row_width squared
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned DIV_STAGES = 6;         // 12 quotient bits, 2 per stage

  localparam logic [CFG_IDX_W-1:0] REG_LATTICE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 1'd1;

  localparam logic [MODE_W-1:0] MODE_RESET  = 2'd0;
  localparam logic [RW_W-1:0]   WIDTH_RESET = 13'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_VON_NEUMANN = 2'd0,
    MODE_MOORE       = 2'd1,
    MODE_RING        = 2'd2
  } tlni_mode_e;

  // Slot order: NW NE SW SE N S E W; Moore starts at the first slot, the others part way in.
  localparam logic [SLOT_W-1:0] SLOT_MOORE_FIRST = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_VN_FIRST    = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_RING_FIRST  = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_LAST        = 3'd7;

  typedef enum logic [1:0] {
    H_NONE,
    H_WEST,
    H_EAST
  } tlni_hdir_e;

  typedef enum logic [1:0] {
    V_NONE,
    V_NORTH,
    V_SOUTH
  } tlni_vdir_e;

  // Classification of one queued item
  typedef struct packed {
    logic              bad;
    logic [SLOT_W-1:0] first_slot;
    logic              col_first;
    logic              col_last;
    logic              row_first;
    logic              row_last;
  } tlni_flags_t;

  typedef struct packed {
    logic [RW_W-1:0]  rem;
    logic [IDX_W-1:0] dq;   // dividend bits shift out, quotient bits shift in
  } tlni_div_t;

  function automatic tlni_hdir_e horiz_of(logic [SLOT_W-1:0] slot);
    tlni_hdir_e h;
    unique case (slot)
      3'd0, 3'd2, 3'd7: h = H_WEST;
      3'd1, 3'd3, 3'd6: h = H_EAST;
      default:          h = H_NONE;
    endcase
    return h;
  endfunction

  function automatic tlni_vdir_e vert_of(logic [SLOT_W-1:0] slot);
    tlni_vdir_e v;
    unique case (slot)
      3'd0, 3'd1, 3'd4: v = V_NORTH;
      3'd2, 3'd3, 3'd5: v = V_SOUTH;
      default:          v = V_NONE;
    endcase
    return v;
  endfunction

  // One restoring divide step
  function automatic tlni_div_t div_step(tlni_div_t x, logic [RW_W-1:0] w);
    logic [RW_W:0] t;
    logic          q;
    tlni_div_t     r;
    t = {x.rem, x.dq[IDX_W-1]};
    q = (t >= {1'b0, w});
    r.rem = q ? RW_W'(t - {1'b0, w}) : t[RW_W-1:0];
    r.dq  = {x.dq[IDX_W-2:0], q};
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/torus_lattice_neighbor_index_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// torus_lattice_neighbor_index_core: neighbor indices on a wrapping lattice
// Takes a cell index and returns its neighbors on a torus (von Neumann or
// Moore) or a ring, one transaction per neighbor, in fixed slot order.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  ---------------------------
//  input     in         in_valid_i / in_stall_o    agent_index_i
//  output    out        out_valid_o / out_stall_i  neighbor_index_o, is_last_o,
//                                                  bad_index_o
//  config    in         cfg_we_i (no handshake)    cfg_idx_i, cfg_wdata_i
//
// Output: one result per cycle from the output register while out_stall_i
//   is low, so an item gives 8 results (Moore), 4 (von Neumann), 2 (ring)
//   or 1 (bad index); the back sequencer's single result port sets this.
//   Input is taken every cycle while the queue has room. Path to a result:
//   product, 6 divide stages of two quotient bits each, queue, output reg.
// Reset: asynchronous, clears pipeline valids, queue pointers, sequencer;
//   lattice_mode returns to von Neumann and row_width to 64.
// Stalls: out_stall_i holds the output register; the queue fills, then the
//   front pipeline freezes as a whole and raises in_stall_o.
//
module torus_lattice_neighbor_index_core #(
  parameter int unsigned MAX_CELLS = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tlni_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlni_pkg::RW_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tlni_pkg::IDX_W-1:0]      agent_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tlni_pkg::IDX_W-1:0]      neighbor_index_o,
  output logic                            is_last_o,
  output logic                            bad_index_o
);
  import tlni_pkg::*;

  // value width: holds any in-range index and any usable row_width
  localparam int unsigned CW     = $clog2(MAX_CELLS) + 1;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QW     = $bits(tlni_flags_t) + 3 * CW;

  logic [MODE_W-1:0] lattice_mode_q;
  logic [RW_W-1:0]   row_width_q;

  // config registers; the user must write them only while idle (not enforced here)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lattice_mode_q <= MODE_RESET;
      row_width_q    <= WIDTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LATTICE_MODE: lattice_mode_q <= cfg_wdata_i[MODE_W-1:0];
        REG_ROW_WIDTH:    row_width_q    <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  // front -> queue
  logic          f_push;
  logic          q_full;
  tlni_flags_t   f_flags;
  logic [CW-1:0] f_idx, f_wid, f_popmw;

  // queue -> back
  logic          q_vld;
  logic          q_pop;
  logic [QW-1:0] q_rdata;
  tlni_flags_t   b_flags;
  logic [CW-1:0] b_idx, b_wid, b_popmw;

  tlni_front #(
    .MAX_CELLS (MAX_CELLS),
    .CW        (CW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .agent_index_i  (agent_index_i),
    .lattice_mode_i (lattice_mode_q),
    .row_width_i    (row_width_q),
    .push_o         (f_push),
    .full_i         (q_full),
    .flags_o        (f_flags),
    .idx_o          (f_idx),
    .wid_o          (f_wid),
    .popmw_o        (f_popmw)
  );

  tlni_fifo #(
    .WIDTH (QW),
    .DEPTH (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i ({f_flags, f_idx, f_wid, f_popmw}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_vld),
    .rdata_o (q_rdata)
  );

  assign {b_flags, b_idx, b_wid, b_popmw} = q_rdata;

  tlni_back #(
    .CW (CW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_vld),
    .flags_i          (b_flags),
    .idx_i            (b_idx),
    .wid_i            (b_wid),
    .popmw_i          (b_popmw),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .neighbor_index_o (neighbor_index_o),
    .is_last_o        (is_last_o),
    .bad_index_o      (bad_index_o)
  );

  // a rejected index is a single, zero-valued transaction
  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_index_o |-> is_last_o && (neighbor_index_o == '0))
    else $error("bad index result not a single zero transaction");

  // queue never written when full, never read when empty
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_push |-> !q_full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_vld)
    else $error("queue pop while empty");

  // a popped entry ends on the last slot of the sequence
  a_pop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o && is_last_o)
    else $error("queue entry retired before its last neighbor");

endmodule
`default_nettype wire

// ----- src/tlni_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlni_front: accept, divide and classify
// Pipelined restoring divider giving row and column, range check against
// the population, edge flags and the first slot of the neighbor sequence.
// ----------------------------------------------------------------------------
module tlni_front #(
  parameter int unsigned MAX_CELLS = 4096,
  parameter int unsigned CW        = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tlni_pkg::IDX_W-1:0]          agent_index_i,
  input  logic [tlni_pkg::MODE_W-1:0]         lattice_mode_i,
  input  logic [tlni_pkg::RW_W-1:0]           row_width_i,
  output logic                                push_o,
  input  logic                                full_i,
  output tlni_pkg::tlni_flags_t               flags_o,
  output logic [CW-1:0]                       idx_o,
  output logic [CW-1:0]                       wid_o,
  output logic [CW-1:0]                       popmw_o
);
  import tlni_pkg::*;

  localparam logic [POP_W-1:0] MaxPop = POP_W'(MAX_CELLS);

  logic                  adv;
  logic [DIV_STAGES:0]   vld_q;
  logic [POP_W-1:0]      prod_q;
  logic [RW_W-1:0]       rem_q   [DIV_STAGES+1];
  logic [IDX_W-1:0]      dq_q    [DIV_STAGES+1];
  logic [IDX_W-1:0]      idx_q   [DIV_STAGES+1];
  logic [RW_W-1:0]       wid_q   [DIV_STAGES+1];
  logic [MODE_W-1:0]     mode_q  [DIV_STAGES+1];
  logic [DIV_STAGES:1]   bad_q;
  logic [CW-1:0]         popmw_q [DIV_STAGES+1];
  tlni_div_t             step_d  [DIV_STAGES+1];
  logic [POP_W-1:0]      pop;
  logic                  bad_d;
  logic [RW_W-1:0]       wm1;

  // whole pipeline holds while the queue cannot take the last stage
  assign adv        = !(vld_q[DIV_STAGES] && full_i);
  assign in_stall_o = !adv;

  always_comb begin
    step_d[0] = '0;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      step_d[k] = div_step(div_step(tlni_div_t'{rem: rem_q[k-1], dq: dq_q[k-1]},
                                    wid_q[k-1]),
                           wid_q[k-1]);
    end
  end

  // range check from the stage 0 product
  always_comb begin
    pop   = (mode_q[0] == MODE_RING) ? POP_W'(wid_q[0]) : prod_q;
    bad_d = (mode_q[0] != MODE_VON_NEUMANN && mode_q[0] != MODE_MOORE &&
             mode_q[0] != MODE_RING) ||
            (wid_q[0] == '0) || (pop > MaxPop) || (POP_W'(idx_q[0]) >= pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DIV_STAGES-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]   <= '0;
      dq_q[0]    <= agent_index_i;
      idx_q[0]   <= agent_index_i;
      wid_q[0]   <= row_width_i;
      mode_q[0]  <= lattice_mode_i;
      popmw_q[0] <= '0;
      prod_q     <= POP_W'(row_width_i) * POP_W'(row_width_i);
      bad_q[1]   <= bad_d;
      popmw_q[1] <= CW'(pop - POP_W'(wid_q[0]));
      for (int k = 1; k <= DIV_STAGES; k++) begin
        rem_q[k]  <= step_d[k].rem;
        dq_q[k]   <= step_d[k].dq;
        idx_q[k]  <= idx_q[k-1];
        wid_q[k]  <= wid_q[k-1];
        mode_q[k] <= mode_q[k-1];
      end
      for (int k = 2; k <= DIV_STAGES; k++) begin
        bad_q[k]   <= bad_q[k-1];
        popmw_q[k] <= popmw_q[k-1];
      end
    end
  end

  // classify the finished division: quotient is the row, remainder the column
  assign wm1 = wid_q[DIV_STAGES] - RW_W'(1);

  always_comb begin
    flags_o.bad       = bad_q[DIV_STAGES];
    flags_o.col_first = (rem_q[DIV_STAGES] == '0);
    flags_o.col_last  = (rem_q[DIV_STAGES] == wm1);
    flags_o.row_first = (dq_q[DIV_STAGES] == '0);
    flags_o.row_last  = (RW_W'(dq_q[DIV_STAGES]) == wm1);
    priority if (bad_q[DIV_STAGES])                 flags_o.first_slot = SLOT_LAST;
    else if (mode_q[DIV_STAGES] == MODE_MOORE)       flags_o.first_slot = SLOT_MOORE_FIRST;
    else if (mode_q[DIV_STAGES] == MODE_RING)        flags_o.first_slot = SLOT_RING_FIRST;
    else                                             flags_o.first_slot = SLOT_VN_FIRST;
  end

  assign push_o  = vld_q[DIV_STAGES] && !full_i;
  assign idx_o   = CW'(idx_q[DIV_STAGES]);
  assign wid_o   = CW'(wid_q[DIV_STAGES]);
  assign popmw_o = popmw_q[DIV_STAGES];

endmodule
`default_nettype wire

// ----- src/tlni_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlni_fifo: short queue between the front and back parts
// Register based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module tlni_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]    LastPtr = PW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] Full    = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ----- src/tlni_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlni_back: neighbor sequencer
// Walks the slots of the head item, forms each neighbor as the cell index
// plus a horizontal and a vertical wrap offset, and drives the output register.
// ----------------------------------------------------------------------------
module tlni_back #(
  parameter int unsigned CW = 13
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  tlni_pkg::tlni_flags_t       flags_i,
  input  logic [CW-1:0]               idx_i,
  input  logic [CW-1:0]               wid_i,
  input  logic [CW-1:0]               popmw_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tlni_pkg::IDX_W-1:0]  neighbor_index_o,
  output logic                        is_last_o,
  output logic                        bad_index_o
);
  import tlni_pkg::*;

  localparam logic [CW-1:0] One = CW'(1);

  logic                 out_vld_q;
  logic [IDX_W-1:0]     nb_q;
  logic                 last_q, bad_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 mid_q;
  logic                 load;
  logic [SLOT_W-1:0]    cur_slot;
  logic                 cur_last;
  logic [CW-1:0]        dh, dv, nb;

  assign load     = q_valid_i && (!out_vld_q || !out_stall_i);
  assign cur_slot = mid_q ? slot_q : flags_i.first_slot;
  assign cur_last = (cur_slot == SLOT_LAST);
  assign q_pop_o  = load && cur_last;

  always_comb begin
    unique case (horiz_of(cur_slot))
      H_WEST:  dh = flags_i.col_first ? wid_i - One : '1;
      H_EAST:  dh = flags_i.col_last ? One - wid_i : One;
      default: dh = '0;
    endcase
    unique case (vert_of(cur_slot))
      V_NORTH: dv = flags_i.row_first ? popmw_i : '0 - wid_i;
      V_SOUTH: dv = flags_i.row_last ? '0 - popmw_i : wid_i;
      default: dv = '0;
    endcase
    nb = flags_i.bad ? '0 : idx_i + dh + dv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      slot_q    <= '0;
      mid_q     <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        slot_q    <= cur_slot + SLOT_W'(1);
        mid_q     <= !cur_last;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      nb_q   <= IDX_W'(nb);
      last_q <= cur_last;
      bad_q  <= flags_i.bad;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign neighbor_index_o = nb_q;
  assign is_last_o        = last_q;
  assign bad_index_o      = bad_q;

endmodule
`default_nettype wire

// ----- tb/tb_torus_lattice_neighbor_index_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_torus_lattice_neighbor_index_core: self-checking bench for the indexer
// Sends cell indices under a series of lattice settings, predicts each
// neighbor transaction in a scoreboard class and compares every result
// field by field. Random gaps on the input side and random stalls on the
// output side, one long output hold-off and drain pauses between settings.
// ----------------------------------------------------------------------------
module tb_torus_lattice_neighbor_index_core;
  import tlni_pkg::*;

  localparam int unsigned MAX_CELLS    = 4096;
  localparam int unsigned LIMIT        = 1000000;  // cycles before timeout
  localparam int unsigned HOLD_CYCLES  = 200;      // long receiver hold-off
  localparam int unsigned SETTLE       = 16;       // longer than the front pipeline latency
  localparam int unsigned RANDOM_SETS  = 8;
  localparam int unsigned ITEMS_PER_SET = 46;

  // lattice_mode value left unused by the block; every index comes back bad
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] nbr;
    logic             last;
    logic             bad;
  } neighbor_rec_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the two registers, expected neighbor queue
  // --------------------------------------------------------------------------
  class neighbor_scoreboard;
    neighbor_rec_t    pending_q[$];
    logic [MODE_W-1:0] mode;
    logic [RW_W-1:0]   width;
    int unsigned       errors;
    int unsigned       checked;

    function new();
      mode    = MODE_RESET;
      width   = WIDTH_RESET;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RW_W-1:0] data);
      if (idx == REG_LATTICE_MODE) mode = data[MODE_W-1:0];
      else if (idx == REG_ROW_WIDTH) width = data;
    endfunction

    // single steps on the wrapping lattice
    function int unsigned west_of(int unsigned i, int unsigned w);
      return (i % w == 0) ? i + w - 1 : i - 1;
    endfunction

    function int unsigned east_of(int unsigned i, int unsigned w);
      return (i % w == w - 1) ? i + 1 - w : i + 1;
    endfunction

    function int unsigned north_of(int unsigned i, int unsigned w);
      return (i / w == 0) ? w * (w - 1) + i % w : i - w;
    endfunction

    function int unsigned south_of(int unsigned i, int unsigned w);
      return (i / w == w - 1) ? i % w : i + w;
    endfunction

    // accepted input transaction: queue the neighbors it must produce
    function void note_index(logic [IDX_W-1:0] cell_idx);
      int unsigned   i;
      int unsigned   w;
      int unsigned   pop;
      int unsigned   nbrs[$];
      neighbor_rec_t rec;
      i   = cell_idx;
      w   = width;
      pop = (mode == MODE_RING) ? w : w * w;
      if (mode == MODE_UNUSED || w == 0 || pop > MAX_CELLS || i >= pop) begin
        rec = '{nbr: '0, last: 1'b1, bad: 1'b1};
        pending_q.push_back(rec);
        return;
      end
      // diagonals step east or west first, then north or south
      if (mode == MODE_MOORE) begin
        nbrs.push_back(north_of(west_of(i, w), w));
        nbrs.push_back(north_of(east_of(i, w), w));
        nbrs.push_back(south_of(west_of(i, w), w));
        nbrs.push_back(south_of(east_of(i, w), w));
      end
      if (mode != MODE_RING) begin
        nbrs.push_back(north_of(i, w));
        nbrs.push_back(south_of(i, w));
      end
      nbrs.push_back(east_of(i, w));
      nbrs.push_back(west_of(i, w));
      foreach (nbrs[k]) begin
        rec.nbr  = nbrs[k][IDX_W-1:0];
        rec.last = (k == nbrs.size() - 1);
        rec.bad  = 1'b0;
        pending_q.push_back(rec);
      end
    endfunction

    // accepted output transaction: compare with the oldest expectation
    function void check_result(logic [IDX_W-1:0] nbr, logic last, logic bad);
      neighbor_rec_t exp_rec;
      if (pending_q.size() == 0) begin
        $error("unexpected result: neighbor_index %0d is_last %0b bad_index %0b",
               nbr, last, bad);
        errors++;
        return;
      end
      exp_rec = pending_q.pop_front();
      checked++;
      if (nbr !== exp_rec.nbr) begin
        $error("neighbor_index: expected %0d, actual %0d", exp_rec.nbr, nbr);
        errors++;
      end
      if (last !== exp_rec.last) begin
        $error("is_last: expected %0b, actual %0b", exp_rec.last, last);
        errors++;
      end
      if (bad !== exp_rec.bad) begin
        $error("bad_index: expected %0b, actual %0b", exp_rec.bad, bad);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [RW_W-1:0]      cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [IDX_W-1:0]     agent_index_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [IDX_W-1:0]     neighbor_index_o;
  logic                 is_last_o;
  logic                 bad_index_o;

  neighbor_scoreboard sb = new();

  int unsigned cycles       = 0;
  int unsigned items_sent   = 0;
  int unsigned settings_cnt = 0;
  logic        calm         = 1'b0;  // no gaps and no stalls while set
  logic        hold_req     = 1'b0;  // asks the receiver for a long hold-off

  torus_lattice_neighbor_index_core #(
    .MAX_CELLS(MAX_CELLS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .agent_index_i   (agent_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .neighbor_index_o(neighbor_index_o),
    .is_last_o       (is_last_o),
    .bad_index_o     (bad_index_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit: sized well above the slowest legal run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Output monitor: sampled at the edge, so values are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(neighbor_index_o, is_last_o, bad_index_o);
  end

  // --------------------------------------------------------------------------
  // Receiver: alternating free and stalled runs, mostly short, a few long;
  // a hold request pins the stall high for HOLD_CYCLES counted here.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned run;
    logic        stalled;
    run         = 0;
    stalled     = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        run     = 0;
        stalled = 1'b0;
      end else begin
        if (run == 0) begin
          stalled = !stalled;
          if (!stalled) run = $urandom_range(1, 12);
          else if ($urandom_range(0, 99) < 85) run = $urandom_range(1, 3);
          else run = $urandom_range(15, 40);
        end
        run--;
        out_stall_i <= stalled && !calm;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one index and holds it until taken; valid stays high when no gap
  task automatic send_index(logic [IDX_W-1:0] cell_idx);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    agent_index_i <= cell_idx;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_index(cell_idx);
    items_sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every expected result is out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Register writes only with the block idle; spare bits of the mode write
  // carry random data that the block must drop
  task automatic set_lattice(logic [MODE_W-1:0] mode, logic [RW_W-1:0] width);
    logic [RW_W-1:0] mode_word;
    mode_word = {11'($urandom), mode};
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_LATTICE_MODE;
    cfg_wdata_i <= mode_word;
    @(posedge clk_i);
    sb.write_reg(REG_LATTICE_MODE, mode_word);
    cfg_idx_i   <= REG_ROW_WIDTH;
    cfg_wdata_i <= width;
    @(posedge clk_i);
    sb.write_reg(REG_ROW_WIDTH, width);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    settings_cnt++;
  endtask

  // Random index, biased toward lattice edges, with some out of population
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned w;
    int unsigned pop;
    int unsigned rows;
    int unsigned row;
    int unsigned col;
    w   = sb.width;
    pop = (sb.mode == MODE_RING) ? w : w * w;
    if (sb.mode == MODE_UNUSED || w == 0 || pop > MAX_CELLS ||
        $urandom_range(0, 99) < 12)
      return IDX_W'($urandom);
    rows = (sb.mode == MODE_RING) ? 1 : w;
    case ($urandom_range(0, 3))
      0:       row = 0;
      1:       row = rows - 1;
      default: row = $urandom_range(0, rows - 1);
    endcase
    case ($urandom_range(0, 3))
      0:       col = 0;
      1:       col = w - 1;
      default: col = $urandom_range(0, w - 1);
    endcase
    return IDX_W'(row * w + col);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    logic [MODE_W-1:0] mode;
    logic [RW_W-1:0]   width;
    int unsigned       r;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_LATTICE_MODE;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    agent_index_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: von Neumann on a 64 x 64 torus, corners
    send_index(12'd0);
    send_index(12'd4095);
    send_index(12'd63);
    send_index(12'd4032);

    // Moore, full population, corners and an interior cell
    set_lattice(MODE_MOORE, 13'd64);
    send_index(12'd0);
    send_index(12'd4095);
    send_index(12'd2080);

    // single-cell torus wraps onto itself, index 1 is outside; then a 2 x 2 corner
    set_lattice(MODE_MOORE, 13'd1);
    send_index(12'd0);
    send_index(12'd1);
    set_lattice(MODE_MOORE, 13'd2);
    send_index(12'd3);

    // Ring at the largest population and the smallest
    set_lattice(MODE_RING, 13'd4096);
    send_index(12'd0);
    send_index(12'd4095);
    set_lattice(MODE_RING, 13'd1);
    send_index(12'd0);

    // Populations above the cell limit, zero width, unused mode
    set_lattice(MODE_RING, 13'd8191);
    send_index(12'd5);
    set_lattice(MODE_VON_NEUMANN, 13'd65);
    send_index(12'd0);
    set_lattice(MODE_VON_NEUMANN, 13'd0);
    send_index(12'd0);
    set_lattice(MODE_UNUSED, 13'd8);
    send_index(12'd0);

    // Index just inside and just outside a 3 x 3 torus
    set_lattice(MODE_VON_NEUMANN, 13'd3);
    send_index(12'd8);
    send_index(12'd9);

    // Backpressure: receiver holds off while Moore items keep coming, so the
    // queue fills and the input stalls; then the sender waits for a drain
    set_lattice(MODE_MOORE, 13'd16);
    calm     = 1'b1;
    hold_req = 1'b1;
    repeat (30) send_index(pick_index());
    calm = 1'b0;
    wait_drained();

    // Random settings, each with a burst of random indices
    for (int ph = 0; ph < RANDOM_SETS; ph++) begin
      mode = ($urandom_range(0, 99) < 8) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));
      r    = $urandom_range(0, 99);
      if (mode == MODE_RING) begin
        if (r < 8)       width = ($urandom_range(0, 1) != 0) ? 13'd1 : 13'd4096;
        else if (r < 16) width = RW_W'($urandom_range(4097, 8191));
        else             width = RW_W'($urandom_range(2, 300));
      end else begin
        if (r < 8)       width = ($urandom_range(0, 1) != 0) ? 13'd1 : 13'd64;
        else if (r < 16) width = RW_W'($urandom_range(65, 8191));
        else             width = RW_W'($urandom_range(2, 24));
      end
      set_lattice(mode, width);
      calm = (ph == 2 || ph == 5);
      repeat (ITEMS_PER_SET) send_index(pick_index());
      calm = 1'b0;
    end

    // Let stray results show up before the verdict
    wait_drained();
    repeat (SETTLE * 2) @(posedge clk_i);

    $display("Covered %0d cell indices over %0d lattice settings plus reset values,",
             items_sent, settings_cnt);
    $display("checking %0d neighbor transactions under gaps, stalls and a long hold.",
             sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- torus_lattice_neighbor_index_core.f -----
src/tlni_pkg.sv
src/tlni_front.sv
src/tlni_fifo.sv
src/tlni_back.sv
src/torus_lattice_neighbor_index_core.sv
tb/tb_torus_lattice_neighbor_index_core.sv
